>>> design/kdef_pkg.sv
// ----------------------------------------------------------------------------
// kdef_pkg
// Shared types, codes and constant tables of the key debounce event block.
// ----------------------------------------------------------------------------
package kdef_pkg;

  localparam int CODE_W    = 5;
  localparam int MASK_W    = 6;
  localparam int PINS_W    = 4;
  localparam int KIDX_W    = 3;
  localparam int FILTER_W  = 7;
  localparam int LONG_W    = 16;
  localparam int REPEAT_W  = 8;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [LONG_W-1:0]   LONG_RESET   = 16'd100;
  localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd0;
  // debounce counters start at half the reset filter length
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(FILTER_RESET / 2);

  typedef enum logic [1:0] {
    CMD_SCAN    = 2'd0,
    CMD_POP_ONE = 2'd1,
    CMD_POP_TWO = 2'd2,
    CMD_CLR_ONE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER = 2'd0,
    CFG_LONG   = 2'd1,
    CFG_REPEAT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EVT_DOWN = 2'd1,
    EVT_UP   = 2'd2,
    EVT_LONG = 2'd3
  } evt_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_PUSH2 = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0]  cnt;
    logic                pressed;
    logic [LONG_W-1:0]   hold;
    logic [REPEAT_W-1:0] rpt;
  } key_state_t;

  typedef struct packed {
    key_state_t        state;
    logic              a_vld;
    logic [CODE_W-1:0] a_code;
    logic              b_vld;
    logic [CODE_W-1:0] b_code;
  } key_upd_t;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] push_code;
    logic              pop_one;
    logic              pop_two;
    logic              clear_one;
  } fifo_req_t;

  // pin levels {key2, key1, key0, wakeup} that select each virtual key
  function automatic logic [PINS_W-1:0] key_pattern(input logic [KIDX_W-1:0] k);
    logic [PINS_W-1:0] p;
    unique case (k)
      3'd0:    p = 4'h1;
      3'd1:    p = 4'h2;
      3'd2:    p = 4'h4;
      3'd3:    p = 4'h8;
      3'd4:    p = 4'h3;
      3'd5:    p = 4'h6;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

  // code = 3*k + kind
  function automatic logic [CODE_W-1:0] event_code(input logic [KIDX_W-1:0] k,
                                                   input evt_e kind);
    logic [CODE_W-1:0] base;
    base = {1'b0, k, 1'b0} + {2'b00, k};
    return base + {3'b000, kind};
  endfunction

endpackage

>>> design/kdef_in_if.sv
// ----------------------------------------------------------------------------
// kdef_in_if
// Command channel: command code and the four pin levels.
// ----------------------------------------------------------------------------
interface kdef_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic                         pin_wakeup;
  logic                         pin_key0;
  logic                         pin_key1;
  logic                         pin_key2;

  modport source (output valid, cmd, pin_wakeup, pin_key0, pin_key1, pin_key2,
                  input ready);
  modport sink   (input valid, cmd, pin_wakeup, pin_key0, pin_key1, pin_key2,
                  output ready);
endinterface

>>> design/kdef_out_if.sv
// ----------------------------------------------------------------------------
// kdef_out_if
// Result channel: popped event code and debounced pressed mask.
// ----------------------------------------------------------------------------
interface kdef_out_if;
  logic                       valid;
  logic                       ready;
  logic [kdef_pkg::CODE_W-1:0] key_code;
  logic [kdef_pkg::MASK_W-1:0] pressed_mask;

  modport source (output valid, key_code, pressed_mask, input ready);
  modport sink   (input valid, key_code, pressed_mask, output ready);
endinterface

>>> design/kdef_cfg_if.sv
// ----------------------------------------------------------------------------
// kdef_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kdef_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kdef_pkg::CFG_IDX_W-1:0] index;
  logic [kdef_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/kdef_key_unit.sv
// ----------------------------------------------------------------------------
// kdef_key_unit
// Shared key updater: decodes one virtual key, steps its debounce, hold and
// repeat counters and produces up to two event codes.
// ----------------------------------------------------------------------------
module kdef_key_unit (
  input  logic [kdef_pkg::KIDX_W-1:0]   key_idx_i,
  input  logic [kdef_pkg::PINS_W-1:0]   pins_i,
  input  logic [kdef_pkg::FILTER_W-1:0] filter_i,
  input  logic [kdef_pkg::LONG_W-1:0]   long_i,
  input  logic [kdef_pkg::REPEAT_W-1:0] repeat_i,
  input  kdef_pkg::key_state_t          state_i,
  output kdef_pkg::key_upd_t            upd_o
);

  logic                           active;
  logic [kdef_pkg::COUNT_W-1:0]   f_one;
  logic [kdef_pkg::COUNT_W-1:0]   f_two;
  logic [kdef_pkg::LONG_W-1:0]    hold_inc;
  logic [kdef_pkg::REPEAT_W-1:0]  rpt_inc;

  assign active   = (pins_i == kdef_pkg::key_pattern(key_idx_i));
  assign f_one    = {1'b0, filter_i};
  assign f_two    = {filter_i, 1'b0};
  assign hold_inc = state_i.hold + 1'b1;
  assign rpt_inc  = state_i.rpt + 1'b1;

  always_comb begin
    upd_o        = '0;
    upd_o.state  = state_i;
    upd_o.a_code = kdef_pkg::event_code(key_idx_i, kdef_pkg::EVT_DOWN);
    upd_o.b_code = kdef_pkg::event_code(key_idx_i, kdef_pkg::EVT_LONG);
    if (active) begin
      priority if (state_i.cnt < f_one) begin
        upd_o.state.cnt = f_one;
      end else if (state_i.cnt < f_two) begin
        upd_o.state.cnt = state_i.cnt + 1'b1;
      end else begin
        if (!state_i.pressed) begin
          upd_o.state.pressed = 1'b1;
          upd_o.a_vld         = 1'b1;
        end
        if (long_i != '0) begin
          if (state_i.hold < long_i) begin
            upd_o.state.hold = hold_inc;
            upd_o.b_vld      = (hold_inc == long_i);
          end else if (repeat_i != '0) begin
            // repeat re-issues the press code
            if (rpt_inc >= repeat_i) begin
              upd_o.state.rpt = '0;
              upd_o.b_vld     = 1'b1;
              upd_o.b_code    = kdef_pkg::event_code(key_idx_i, kdef_pkg::EVT_DOWN);
            end else begin
              upd_o.state.rpt = rpt_inc;
            end
          end
        end
      end
    end else begin
      priority if (state_i.cnt > f_one) begin
        upd_o.state.cnt = f_one;
      end else if (state_i.cnt != '0) begin
        upd_o.state.cnt = state_i.cnt - 1'b1;
      end else begin
        if (state_i.pressed) begin
          upd_o.state.pressed = 1'b0;
          upd_o.a_vld         = 1'b1;
          upd_o.a_code        = kdef_pkg::event_code(key_idx_i, kdef_pkg::EVT_UP);
        end
      end
      upd_o.state.hold = '0;
      upd_o.state.rpt  = '0;
    end
  end

endmodule

>>> design/kdef_event_fifo.sv
// ----------------------------------------------------------------------------
// kdef_event_fifo
// Event code store with one write pointer and two independent read pointers.
// Pushes never check for room; pops return zero when the reader is empty.
// ----------------------------------------------------------------------------
module kdef_event_fifo #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kdef_pkg::fifo_req_t         req_i,
  output logic [kdef_pkg::CODE_W-1:0] rd_code_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic [kdef_pkg::CODE_W-1:0] mem [FIFO_DEPTH];
  logic [kdef_pkg::CODE_W-1:0] rd_data_q;
  logic                        rd_empty_q;
  logic [PTR_W-1:0]            wr_ptr_q;
  logic [PTR_W-1:0]            rd_one_q;
  logic [PTR_W-1:0]            rd_two_q;
  logic [PTR_W-1:0]            rd_addr;
  logic                        pop;
  logic                        empty;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop     = req_i.pop_one | req_i.pop_two;
  assign rd_addr = req_i.pop_one ? rd_one_q : rd_two_q;
  assign empty   = (rd_addr == wr_ptr_q);

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[wr_ptr_q] <= req_i.push_code;
    end
    if (pop) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_one_q   <= '0;
      rd_two_q   <= '0;
      rd_empty_q <= 1'b1;
    end else begin
      if (req_i.push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_empty_q <= empty;
      end
      if (req_i.clear_one) begin
        rd_one_q <= wr_ptr_q;
      end else if (req_i.pop_one && !empty) begin
        rd_one_q <= ptr_next(rd_one_q);
      end
      if (req_i.pop_two && !empty) begin
        rd_two_q <= ptr_next(rd_two_q);
      end
    end
  end

  assign rd_code_o = rd_empty_q ? '0 : rd_data_q;

endmodule

>>> design/key_debounce_event_fifo_core.sv
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_core
// Six virtual key debouncer with long-press and auto-repeat events, feeding
// an event store drained by two readers.
// ----------------------------------------------------------------------------
// timing: pop and clear results are loaded into the output reg in the done step,
// pops from the event store read register; scan ticks visit every key in turn,
// with a second push step for each key that pushes two codes, before the done step
// one key updater visits a key a cycle, save a second push step; one write port;
// a new command is taken while the previous result waits in the output reg
// reset: asynchronous, clears hold and repeat counters, flags and pointers, loads defaults.
module key_debounce_event_fifo_core #(
  parameter int FIFO_DEPTH = 16,
  parameter int NUM_KEYS   = 6
) (
  input logic          clk_i,
  input logic          rst_ni,
  kdef_in_if.sink      in_i,
  kdef_out_if.source   out_o,
  kdef_cfg_if.sink     cfg_i
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kdef_pkg::state_e                 state_q, state_d;
  kdef_pkg::cmd_e                   cmd_q;
  kdef_pkg::cmd_e                   cmd_in;
  logic [kdef_pkg::PINS_W-1:0]      pins_q;
  logic [KEY_W-1:0]                 key_idx_q, key_idx_d;
  logic [kdef_pkg::CODE_W-1:0]      pend_q, pend_d;
  kdef_pkg::key_state_t             key_q [NUM_KEYS];
  kdef_pkg::key_upd_t               upd;
  kdef_pkg::fifo_req_t              fifo_req;
  logic [kdef_pkg::CODE_W-1:0]      fifo_code;
  logic                             key_we;
  logic                             out_load;
  logic                             in_xfer;
  logic [kdef_pkg::MASK_W-1:0]      mask;
  logic                             out_valid_q;
  logic [kdef_pkg::CODE_W-1:0]      out_code_q;
  logic [kdef_pkg::MASK_W-1:0]      out_mask_q;
  logic [kdef_pkg::FILTER_W-1:0]    filter_q;
  logic [kdef_pkg::LONG_W-1:0]      long_q;
  logic [kdef_pkg::REPEAT_W-1:0]    repeat_q;

  assign in_i.ready  = (state_q == kdef_pkg::ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cmd_in      = kdef_pkg::cmd_e'(in_i.cmd);
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= kdef_pkg::FILTER_RESET;
      long_q   <= kdef_pkg::LONG_RESET;
      repeat_q <= kdef_pkg::REPEAT_RESET;
    end else if (cfg_i.valid) begin
      unique case (kdef_pkg::cfg_idx_e'(cfg_i.index))
        kdef_pkg::CFG_FILTER: filter_q <= cfg_i.data[kdef_pkg::FILTER_W-1:0];
        kdef_pkg::CFG_LONG:   long_q   <= cfg_i.data[kdef_pkg::LONG_W-1:0];
        kdef_pkg::CFG_REPEAT: repeat_q <= cfg_i.data[kdef_pkg::REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  kdef_key_unit u_key_unit (
    .key_idx_i (kdef_pkg::KIDX_W'(key_idx_q)),
    .pins_i    (pins_q),
    .filter_i  (filter_q),
    .long_i    (long_q),
    .repeat_i  (repeat_q),
    .state_i   (key_q[key_idx_q]),
    .upd_o     (upd)
  );

  kdef_event_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_event_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .rd_code_o (fifo_code)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    key_idx_d = key_idx_q;
    pend_d    = pend_q;
    fifo_req  = '0;
    key_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      kdef_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_in)
            kdef_pkg::CMD_SCAN: begin
              key_idx_d = '0;
              state_d   = kdef_pkg::ST_SCAN;
            end
            kdef_pkg::CMD_POP_ONE: begin
              fifo_req.pop_one = 1'b1;
              state_d          = kdef_pkg::ST_DONE;
            end
            kdef_pkg::CMD_POP_TWO: begin
              fifo_req.pop_two = 1'b1;
              state_d          = kdef_pkg::ST_DONE;
            end
            kdef_pkg::CMD_CLR_ONE: begin
              fifo_req.clear_one = 1'b1;
              state_d            = kdef_pkg::ST_DONE;
            end
            default: state_d = kdef_pkg::ST_DONE;
          endcase
        end
      end
      kdef_pkg::ST_SCAN: begin
        key_we             = 1'b1;
        fifo_req.push      = upd.a_vld | upd.b_vld;
        fifo_req.push_code = upd.a_vld ? upd.a_code : upd.b_code;
        if (upd.a_vld && upd.b_vld) begin
          // second code of this key goes out next cycle
          pend_d  = upd.b_code;
          state_d = kdef_pkg::ST_PUSH2;
        end else if (key_idx_q == KEY_W'(NUM_KEYS - 1)) begin
          state_d = kdef_pkg::ST_DONE;
        end else begin
          key_idx_d = key_idx_q + 1'b1;
        end
      end
      kdef_pkg::ST_PUSH2: begin
        fifo_req.push      = 1'b1;
        fifo_req.push_code = pend_q;
        if (key_idx_q == KEY_W'(NUM_KEYS - 1)) begin
          state_d = kdef_pkg::ST_DONE;
        end else begin
          key_idx_d = key_idx_q + 1'b1;
          state_d   = kdef_pkg::ST_SCAN;
        end
      end
      kdef_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = kdef_pkg::ST_IDLE;
        end
      end
      default: state_d = kdef_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kdef_pkg::ST_IDLE;
      key_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      key_idx_q <= key_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_xfer) begin
      cmd_q  <= cmd_in;
      pins_q <= {in_i.pin_key2, in_i.pin_key1, in_i.pin_key0, in_i.pin_wakeup};
    end
  end

  // per-key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_q[k].cnt     <= kdef_pkg::COUNT_RESET;
        key_q[k].pressed <= 1'b0;
        key_q[k].hold    <= '0;
        key_q[k].rpt     <= '0;
      end
    end else if (key_we) begin
      key_q[key_idx_q] <= upd.state;
    end
  end

  for (genvar g = 0; g < kdef_pkg::MASK_W; g++) begin : g_mask
    if (g < NUM_KEYS) begin : g_key
      assign mask[g] = key_q[g].pressed;
    end else begin : g_none
      assign mask[g] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= (cmd_q == kdef_pkg::CMD_POP_ONE || cmd_q == kdef_pkg::CMD_POP_TWO)
                    ? fifo_code : '0;
      out_mask_q <= mask;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.key_code     = out_code_q;
  assign out_o.pressed_mask = out_mask_q;

  // a result only appears after the sequencer finished its command
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kdef_pkg::ST_DONE))
    else $error("result raised outside the done step");

  // second push of a key always follows that key's update
  a_push2_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kdef_pkg::ST_PUSH2 |-> $past(state_q == kdef_pkg::ST_SCAN) &&
                                      $stable(key_idx_q))
    else $error("second push not tied to the key just updated");

  // key index stays within the configured key count while scanning
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kdef_pkg::ST_SCAN || state_q == kdef_pkg::ST_PUSH2) |->
      key_idx_q <= KEY_W'(NUM_KEYS - 1))
    else $error("key index out of range");

endmodule

>>> bench/key_debounce_event_fifo_core_test.sv
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_core_test
// Drives scan ticks, pops and clears with random pin levels through the
// command channel, rewrites the timing registers between phases, and checks
// every popped code and pressed mask against a cycle-free key/event predictor.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo_core_test;
  import kdef_pkg::*;

  localparam int KEYS  = 6;
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);

  localparam logic [CODE_W-1:0] NO_EVENT  = '0;
  localparam logic [CODE_W-1:0] KEY0_DOWN = CODE_W'(EVT_DOWN);
  localparam logic [CODE_W-1:0] KEY0_UP   = CODE_W'(EVT_UP);

  // pin levels {key2, key1, key0, wakeup} of each virtual key
  localparam logic [PINS_W-1:0] KEY_PINS [KEYS] = '{4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h6};

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [MASK_W-1:0] mask;
  } kbd_result_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [PINS_W-1:0] pins;
    logic              typed;
    kbd_result_t       want;
  } key_row_t;

  localparam key_row_t DIRECTED_ROWS [25] = '{
    '{CMD_POP_ONE, 4'h0, 1'b1, '{NO_EVENT, 6'h00}},
    '{CMD_POP_TWO, 4'hF, 1'b1, '{NO_EVENT, 6'h00}},
    '{CMD_CLR_ONE, 4'hF, 1'b1, '{NO_EVENT, 6'h00}},
    '{CMD_SCAN,    4'h0, 1'b1, '{NO_EVENT, 6'h00}},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_SCAN,    4'h1, 1'b0, '0},
    '{CMD_POP_ONE, 4'h0, 1'b1, '{KEY0_DOWN, 6'h01}},
    '{CMD_SCAN,    4'hF, 1'b0, '0},
    '{CMD_SCAN,    4'h3, 1'b0, '0},
    '{CMD_POP_TWO, 4'h0, 1'b0, '0},
    '{CMD_SCAN,    4'h6, 1'b0, '0},
    '{CMD_SCAN,    4'h2, 1'b0, '0},
    '{CMD_SCAN,    4'h4, 1'b0, '0},
    '{CMD_SCAN,    4'h8, 1'b0, '0},
    '{CMD_SCAN,    4'h0, 1'b0, '0},
    '{CMD_POP_ONE, 4'hF, 1'b1, '{KEY0_UP, 6'h00}},
    '{CMD_CLR_ONE, 4'h0, 1'b0, '0},
    '{CMD_POP_ONE, 4'h0, 1'b1, '{NO_EVENT, 6'h00}},
    '{CMD_POP_TWO, 4'hF, 1'b0, '0},
    '{CMD_POP_TWO, 4'h0, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kdef_in_if  in_bus ();
  kdef_out_if out_bus ();
  kdef_cfg_if cfg_bus ();

  key_debounce_event_fifo_core #(
    .FIFO_DEPTH(DEPTH),
    .NUM_KEYS  (KEYS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [FILTER_W-1:0] flt_len;
  logic [LONG_W-1:0]   long_len;
  logic [REPEAT_W-1:0] rpt_len;
  logic [COUNT_W-1:0]  deb_cnt    [KEYS];
  logic                is_down    [KEYS];
  logic [LONG_W-1:0]   held_ticks [KEYS];
  logic [REPEAT_W-1:0] rpt_ticks  [KEYS];
  logic [CODE_W-1:0]   evt_mem    [DEPTH];
  logic [PTR_W-1:0]    wr_idx;
  logic [PTR_W-1:0]    rd_one;
  logic [PTR_W-1:0]    rd_two;

  kbd_result_t due_readouts [$];
  kbd_result_t head;
  int unsigned readouts_seen = 0;
  int unsigned bad_fields = 0;
  int unsigned feed_calm = 0;

  function automatic void log_event(input int unsigned k, input evt_e kind);
    evt_mem[wr_idx] = CODE_W'(3 * k + int'(kind));
    wr_idx = wr_idx + 1'b1;  // no room check, wraps over unread entries
  endfunction

  function automatic kbd_result_t keypad_step(input cmd_e c, input logic [PINS_W-1:0] pins);
    kbd_result_t      res;
    logic [PTR_W-1:0] rd;
    int unsigned      lim;
    res = '0;
    lim = int'(flt_len);
    case (c)
      CMD_SCAN: begin
        for (int k = 0; k < KEYS; k++) begin
          if (pins == KEY_PINS[k]) begin
            if (deb_cnt[k] < lim) begin
              deb_cnt[k] = COUNT_W'(lim);
            end else if (deb_cnt[k] < 2 * lim) begin
              deb_cnt[k] = deb_cnt[k] + 1'b1;
            end else begin
              if (!is_down[k]) begin
                is_down[k] = 1'b1;
                log_event(k, EVT_DOWN);
              end
              if (long_len != 0) begin
                if (held_ticks[k] < long_len) begin
                  held_ticks[k] = held_ticks[k] + 1'b1;
                  if (held_ticks[k] == long_len) log_event(k, EVT_LONG);
                end else if (rpt_len != 0) begin
                  rpt_ticks[k] = rpt_ticks[k] + 1'b1;
                  if (rpt_ticks[k] >= rpt_len) begin
                    rpt_ticks[k] = '0;
                    log_event(k, EVT_DOWN);
                  end
                end
              end
            end
          end else begin
            if (deb_cnt[k] > lim) begin
              deb_cnt[k] = COUNT_W'(lim);
            end else if (deb_cnt[k] != 0) begin
              deb_cnt[k] = deb_cnt[k] - 1'b1;
            end else if (is_down[k]) begin
              is_down[k] = 1'b0;
              log_event(k, EVT_UP);
            end
            held_ticks[k] = '0;
            rpt_ticks[k]  = '0;
          end
        end
      end
      CMD_POP_ONE, CMD_POP_TWO: begin
        rd = (c == CMD_POP_ONE) ? rd_one : rd_two;
        if (rd != wr_idx) begin
          res.code = evt_mem[rd];
          rd = rd + 1'b1;
        end
        if (c == CMD_POP_ONE) rd_one = rd;
        else rd_two = rd;
      end
      CMD_CLR_ONE: rd_one = wr_idx;
      default: ;
    endcase
    for (int k = 0; k < KEYS; k++) res.mask[k] = is_down[k];
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    bad_fields++;
    if (bad_fields <= 10) $display("%s: expected %0d, got %0d", what, want, got);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_FILTER: flt_len  = data[FILTER_W-1:0];
      CFG_LONG:   long_len = data[LONG_W-1:0];
      CFG_REPEAT: rpt_len  = data[REPEAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic issue_cmd(input cmd_e c, input logic [PINS_W-1:0] pins, input logic typed,
                           input kbd_result_t want);
    kbd_result_t guess;
    int unsigned gap;
    int unsigned r;
    logic        drain;
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= c;
    in_bus.pin_wakeup <= pins[0];
    in_bus.pin_key0   <= pins[1];
    in_bus.pin_key1   <= pins[2];
    in_bus.pin_key2   <= pins[3];
    do @(posedge clk_i); while (!in_bus.ready);
    guess = keypad_step(c, pins);
    due_readouts.push_back(typed ? want : guess);
    gap   = 0;
    drain = 1'b0;
    if (feed_calm != 0) begin
      feed_calm--;
    end else begin
      r = $urandom_range(0, 199);
      if (r < 4) feed_calm = $urandom_range(20, 80);
      else if (r < 5) drain = 1'b1;
      else if (r < 70) gap = $urandom_range(1, 3);
      else if (r < 76) gap = $urandom_range(8, 40);
    end
    if (drain || gap != 0) begin
      in_bus.valid <= 1'b0;
      // hold off until every outstanding readout is back
      while (drain && due_readouts.size() != 0) @(posedge clk_i);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // held key levels with optional contact bounce, pops and clears in between
  task automatic run_random(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       span;
    int unsigned       seg_len;
    int unsigned       r;
    logic              bouncy;
    logic [PINS_W-1:0] level;
    logic [PINS_W-1:0] pins;
    cmd_e              c;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) level = KEY_PINS[$urandom_range(0, KEYS - 1)];
      else if (r < 88) level = '0;
      else level = PINS_W'($urandom);
      bouncy  = ($urandom_range(0, 1) == 0);
      span    = 2 * flt_len + 3 + ((long_len < 40) ? long_len + 4 * rpt_len + 6 : 20);
      seg_len = $urandom_range(1, span);
      for (int t = 0; t < seg_len && sent < n_items; t++) begin
        pins = (bouncy && $urandom_range(0, 99) < 8) ? PINS_W'($urandom) : level;
        issue_cmd(CMD_SCAN, pins, 1'b0, '0);
        sent++;
        if ($urandom_range(0, 99) < 35 && sent < n_items) begin
          r = $urandom_range(0, 99);
          c = (r < 45) ? CMD_POP_ONE : (r < 90) ? CMD_POP_TWO : CMD_CLR_ONE;
          issue_cmd(c, PINS_W'($urandom), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [FILTER_W-1:0] flt, input logic [LONG_W-1:0] lng,
                           input logic [REPEAT_W-1:0] rpt, input int unsigned n_items);
    in_bus.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk_i);
    // unused upper data bits get noise
    write_reg(CFG_FILTER, {9'($urandom), flt});
    write_reg(CFG_LONG, lng);
    write_reg(CFG_REPEAT, {8'($urandom), rpt});
    cfg_bus.valid <= 1'b0;
    run_random(n_items);
  endtask

  initial begin : stimulus
    flt_len  = FILTER_RESET;
    long_len = LONG_RESET;
    rpt_len  = REPEAT_RESET;
    for (int k = 0; k < KEYS; k++) begin
      deb_cnt[k]    = COUNT_W'(FILTER_RESET / 2);
      is_down[k]    = 1'b0;
      held_ticks[k] = '0;
      rpt_ticks[k]  = '0;
    end
    for (int i = 0; i < DEPTH; i++) evt_mem[i] = '0;
    wr_idx = '0;
    rd_one = '0;
    rd_two = '0;

    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= CMD_SCAN;
    in_bus.pin_wakeup <= 1'b0;
    in_bus.pin_key0   <= 1'b0;
    in_bus.pin_key1   <= 1'b0;
    in_bus.pin_key2   <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_FILTER;
    cfg_bus.data      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      issue_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].pins, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
    end
    run_random(150);
    run_phase(7'd1, 16'd4, 8'd2, 250);
    run_phase(7'd0, 16'd1, 8'd1, 200);
    run_phase(7'd127, 16'd65535, 8'd255, 400);
    run_phase(7'd3, 16'd0, 8'd5, 150);
    run_phase(7'd2, 16'd2, 8'd3, 150);

    in_bus.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("key_debounce_event_fifo_core: match");
    end else begin
      $display("key_debounce_event_fifo_core: mismatch");
    end
    $finish;
  end

  initial begin : result_drain
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned long_holds;
    int unsigned r;
    stall_left = 0;
    calm_left  = 0;
    long_holds = 0;
    out_bus.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_holds < 2 && readouts_seen >= (long_holds + 1) * 400) begin
        // long back-pressure so the command side fills up and stalls
        long_holds++;
        stall_left = 300;
      end else if (stall_left == 0) begin
        if (calm_left != 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) calm_left = $urandom_range(20, 80);
          else if (r < 30) stall_left = $urandom_range(1, 3);
          else if (r < 33) stall_left = $urandom_range(10, 40);
        end
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      readouts_seen++;
      if (due_readouts.size() == 0) begin
        flag_mismatch("readout with nothing pending, code", 0, out_bus.key_code);
      end else begin
        head = due_readouts.pop_front();
        if (out_bus.key_code !== head.code) begin
          flag_mismatch("key_code", head.code, out_bus.key_code);
        end
        if (out_bus.pressed_mask !== head.mask) begin
          flag_mismatch("pressed_mask", head.mask, out_bus.pressed_mask);
        end
      end
    end
  end

  initial begin : watchdog
    #8000000;
    $display("key_debounce_event_fifo_core: mismatch");
    $finish;
  end

endmodule
